FILE: rtl/lcm_by_euclid_gcd_assert.svh
// ----------------------------------------------------------------------------
// lcm_by_euclid_gcd_assert.svh
// Assertion macros shared by the GCD/LCM block. Defining NO_ASSERTIONS
// removes every check.
// ----------------------------------------------------------------------------
`ifndef LCM_BY_EUCLID_GCD_ASSERT_SVH
`define LCM_BY_EUCLID_GCD_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define LCM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcm_by_euclid_gcd: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcm_by_euclid_gcd: assertion failed");

`else

`define LCM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LCM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/lcm_pkg.sv
// ----------------------------------------------------------------------------
// lcm_pkg
// Shared types and constants of the GCD/LCM block.
// ----------------------------------------------------------------------------
package lcm_pkg;

  localparam int OP_W        = 16;
  localparam int PROD_W      = 2 * OP_W;
  localparam int IN_TDATA_W  = ((2 * OP_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((3 * OP_W + 7) / 8) * 8;
  localparam int CNT_W       = (OP_W > 2) ? $clog2(OP_W) : 1;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    KIND_NORMAL,
    KIND_ONE_ZERO,
    KIND_BOTH_ZERO
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [OP_W-1:0]   big;
    logic [OP_W-1:0]   small_op;
  } q_entry_t;

  typedef struct packed {
    logic              start;
    logic [OP_W-1:0]   dividend;
    logic [OP_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [OP_W-1:0]   quotient;
    logic [OP_W-1:0]   remainder;
  } div_rsp_t;

endpackage

FILE: rtl/lcm_front.sv
// ----------------------------------------------------------------------------
// lcm_front
// Accepts operand pairs, orders them and classifies the zero cases.
// ----------------------------------------------------------------------------
module lcm_front
  import lcm_pkg::*;
(
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,   // operand_a, operand_b
  input  logic                  q_full,
  output logic                  push_valid,
  output q_entry_t              push_entry
);

  logic [OP_W-1:0] op_a;
  logic [OP_W-1:0] op_b;

  assign op_a = in_tdata[OP_W-1:0];
  assign op_b = in_tdata[2*OP_W-1:OP_W];

  assign in_tready  = !q_full;
  assign push_valid = in_tvalid && !q_full;

  always_comb begin
    if (op_a > op_b) begin
      push_entry.big      = op_a;
      push_entry.small_op = op_b;
    end else begin
      push_entry.big      = op_b;
      push_entry.small_op = op_a;
    end
    if ((op_a == '0) && (op_b == '0)) begin
      push_entry.kind = KIND_BOTH_ZERO;
    end else if ((op_a == '0) || (op_b == '0)) begin
      push_entry.kind = KIND_ONE_ZERO;
    end else begin
      push_entry.kind = KIND_NORMAL;
    end
  end

endmodule

FILE: rtl/lcm_queue.sv
// ----------------------------------------------------------------------------
// lcm_queue
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module lcm_queue
  import lcm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  input  q_entry_t push_entry,
  output logic     q_full,
  output logic     q_valid,
  output q_entry_t q_entry,
  input  logic     pop
);

  q_entry_t            entries_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic                do_pop;

  assign q_full  = (count_r == QCNT_W'(QDEPTH));
  assign q_valid = (count_r != '0);
  assign q_entry = entries_r[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (push_valid) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_valid) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push_valid && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !push_valid) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/lcm_divider.sv
// ----------------------------------------------------------------------------
// lcm_divider
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lcm_divider
  import lcm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [OP_W-1:0]   rem_r;
  logic [OP_W-1:0]   quo_r;
  logic [OP_W-1:0]   div_r;
  logic [OP_W:0]     trial;
  logic [OP_W:0]     diff;
  logic              fits;

  assign trial = {rem_r, quo_r[OP_W-1]};
  assign diff  = trial - {1'b0, div_r};
  assign fits  = (trial >= {1'b0, div_r});

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      div_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[OP_W-1:0] : trial[OP_W-1:0];
      quo_r <= {quo_r[OP_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !req.start && (cnt_r == CNT_W'(OP_W - 1));
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(OP_W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign rsp.busy      = busy_r;
  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

FILE: rtl/lcm_back.sv
// ----------------------------------------------------------------------------
// lcm_back
// Runs Euclid's loop on the shared divider, forms the LCM as
// (big / gcd) * small and holds the result in the output register.
// ----------------------------------------------------------------------------
module lcm_back
  import lcm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  q_entry_t          q_entry,
  output logic              pop,
  output div_req_t          div_req,
  input  div_rsp_t          div_rsp,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OP_W-1:0]   out_divisor,
  output logic [PROD_W-1:0] out_multiple,
  output logic              out_both_zero
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOD,
    S_QUO,
    S_PUSH
  } state_t;

  state_t              state_r;
  logic                start_r;
  logic [OP_W-1:0]     dividend_r;
  logic [OP_W-1:0]     divisor_r;
  logic [OP_W-1:0]     orig_big_r;
  logic [OP_W-1:0]     orig_small_r;
  logic [OP_W-1:0]     res_div_r;
  logic [PROD_W-1:0]   res_mul_r;
  logic                res_err_r;
  logic                out_valid_r;
  logic [OP_W-1:0]     out_div_r;
  logic [PROD_W-1:0]   out_mul_r;
  logic                out_err_r;
  logic [PROD_W-1:0]   prod;

  assign pop = (state_r == S_IDLE) && q_valid;

  assign prod = {{OP_W{1'b0}}, div_rsp.quotient} * {{OP_W{1'b0}}, orig_small_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= ((state_r == S_IDLE) && q_valid &&
                  (q_entry.kind != KIND_BOTH_ZERO) && (q_entry.kind != KIND_ONE_ZERO)) ||
                 ((state_r == S_MOD) && div_rsp.done);
      if ((state_r == S_PUSH) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            orig_big_r   <= q_entry.big;
            orig_small_r <= q_entry.small_op;
            case (q_entry.kind)
              KIND_BOTH_ZERO: begin
                res_div_r <= '0;
                res_mul_r <= '0;
                res_err_r <= 1'b1;
                state_r   <= S_PUSH;
              end
              KIND_ONE_ZERO: begin
                res_div_r <= q_entry.big;
                res_mul_r <= '0;
                res_err_r <= 1'b0;
                state_r   <= S_PUSH;
              end
              default: begin
                dividend_r <= q_entry.big;
                divisor_r  <= q_entry.small_op;
                state_r    <= S_MOD;
              end
            endcase
          end
        end
        S_MOD: begin
          if (div_rsp.done) begin
            if (div_rsp.remainder == '0) begin
              res_div_r  <= divisor_r;
              dividend_r <= orig_big_r;
              state_r    <= S_QUO;
            end else begin
              dividend_r <= divisor_r;
              divisor_r  <= div_rsp.remainder;
            end
          end
        end
        S_QUO: begin
          if (div_rsp.done) begin
            res_mul_r <= prod;
            res_err_r <= 1'b0;
            state_r   <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!out_valid_r || out_tready) begin
            out_div_r   <= res_div_r;
            out_mul_r   <= res_mul_r;
            out_err_r   <= res_err_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign div_req.start    = start_r;
  assign div_req.dividend = dividend_r;
  assign div_req.divisor  = divisor_r;

  assign out_tvalid    = out_valid_r;
  assign out_divisor   = out_div_r;
  assign out_multiple  = out_mul_r;
  assign out_both_zero = out_err_r;

endmodule

FILE: rtl/lcm_by_euclid_gcd.sv
// ----------------------------------------------------------------------------
// lcm_by_euclid_gcd
// Greatest common divisor and least common multiple of two unsigned operands.
//
//   Channel  Direction  Payload
//   in_*     slave      tdata: operand_a, operand_b
//   out_*    master     tdata: divisor, multiple; tuser: both_zero
//
// A pair with a zero operand bypasses the divider. Otherwise every Euclid
// step and the final big / gcd quotient use one shared divider that yields
// one bit per cycle. Reset is synchronous and active low. A short queue
// lets the input side keep accepting, until it fills, while the divider is
// busy or the output transaction is stalled.
// ----------------------------------------------------------------------------
`include "lcm_by_euclid_gcd_assert.svh"

module lcm_by_euclid_gcd
  import lcm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // operand_a, operand_b
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // divisor, multiple
  output logic                   out_tuser   // both_zero
);

  logic              q_full;
  logic              push_valid;
  q_entry_t          push_entry;
  logic              q_valid;
  q_entry_t          q_entry;
  logic              pop;
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic [OP_W-1:0]   res_divisor;
  logic [PROD_W-1:0] res_multiple;

  lcm_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_entry (push_entry)
  );

  lcm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .q_full     (q_full),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .pop        (pop)
  );

  lcm_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  lcm_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_entry       (q_entry),
    .pop           (pop),
    .div_req       (div_req),
    .div_rsp       (div_rsp),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_divisor   (res_divisor),
    .out_multiple  (res_multiple),
    .out_both_zero (out_tuser)
  );

  assign out_tdata = OUT_TDATA_W'({res_multiple, res_divisor});

  `LCM_ASSERT_IMP(a_zero_result, clk, rst_n, out_tvalid && out_tuser, out_tdata == '0)
  `LCM_ASSERT_IMP(a_divisor_set, clk, rst_n, out_tvalid && !out_tuser, res_divisor != '0)
  `LCM_ASSERT_IMP(a_div_idle_start, clk, rst_n, div_req.start, !div_rsp.busy)
  `LCM_ASSERT_NEXT(a_div_nonzero, clk, rst_n, div_req.start, div_req.divisor != '0)

endmodule
